/* rtl/smd_pkg.sv */
// ----------------------------------------------------------------------------
// smd_pkg: shared types and constants for the sliding median spike detector
// Default sizes, configuration width and the control groups that the top level
// drives into the sorting cells and the history line.
// ----------------------------------------------------------------------------
package smd_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS        = 7;
    localparam int COUNT_BITS      = 32;

    typedef struct packed {
        logic clear;
        logic sort;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic rotate;
        logic push;
    } hist_ctrl_t;

endpackage

/* rtl/smd_if.sv */
// ----------------------------------------------------------------------------
// smd_if: request channels of the sliding median spike detector
// One channel for incoming samples, one for result requests.
// ----------------------------------------------------------------------------
interface smd_in_if #(
    parameter int SAMPLE_BITS = smd_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface smd_out_if #(
    parameter int SAMPLE_BITS = smd_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          window_ready;
    logic                          alert;
    logic [SAMPLE_BITS:0]          twice_median;
    logic [smd_pkg::COUNT_BITS-1:0] alert_count;

    modport source (output valid, output window_ready, output alert,
                    output twice_median, output alert_count, input ready);
    modport sink   (input valid, input window_ready, input alert,
                    input twice_median, input alert_count, output ready);
endinterface

/* rtl/smd_sort_cell.sv */
// ----------------------------------------------------------------------------
// smd_sort_cell: one cell of the systolic insertion sorter
// Keeps the smaller of its held value and the incoming one, passes the larger
// to the next cell; in shift mode takes the value of its right neighbor.
// ----------------------------------------------------------------------------
module smd_sort_cell #(
    parameter int SAMPLE_BITS = smd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  smd_pkg::cell_ctrl_t     ctrl,
    input  logic                    in_valid,
    input  logic [SAMPLE_BITS-1:0]  in_data,
    input  logic [SAMPLE_BITS-1:0]  shift_data,
    output logic [SAMPLE_BITS-1:0]  held,
    output logic                    pass_valid,
    output logic [SAMPLE_BITS-1:0]  pass_data
);

    logic                   occ_reg;
    logic                   occ_next;
    logic                   pass_valid_reg;
    logic                   pass_valid_next;
    logic [SAMPLE_BITS-1:0] held_reg;
    logic [SAMPLE_BITS-1:0] held_next;
    logic [SAMPLE_BITS-1:0] pass_data_reg;
    logic [SAMPLE_BITS-1:0] pass_data_next;

    always_comb
    begin
        occ_next        = occ_reg;
        pass_valid_next = pass_valid_reg;
        held_next       = held_reg;
        pass_data_next  = pass_data_reg;
        priority if (ctrl.clear)
        begin
            occ_next        = 1'b0;
            pass_valid_next = 1'b0;
        end
        else if (ctrl.sort)
        begin
            pass_valid_next = 1'b0;
            if (in_valid)
            begin
                if (!occ_reg)
                begin
                    held_next = in_data;
                    occ_next  = 1'b1;
                end
                else if (in_data < held_reg)
                begin
                    held_next       = in_data;
                    pass_data_next  = held_reg;
                    pass_valid_next = 1'b1;
                end
                else
                begin
                    pass_data_next  = in_data;
                    pass_valid_next = 1'b1;
                end
            end
        end
        else if (ctrl.shift)
        begin
            held_next = shift_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg        <= 1'b0;
            pass_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg        <= occ_next;
            pass_valid_reg <= pass_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        pass_data_reg <= pass_data_next;
    end

    assign held       = held_reg;
    assign pass_valid = pass_valid_reg;
    assign pass_data  = pass_data_reg;

endmodule

/* rtl/smd_hist.sv */
// ----------------------------------------------------------------------------
// smd_hist: sample history line
// Entry 0 is the newest sample. Push shifts a new sample in; rotate moves every
// entry one place toward the head so the window streams out of entry 0.
// ----------------------------------------------------------------------------
module smd_hist #(
    parameter int WINDOW_MAX  = smd_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = smd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                    clk,
    input  smd_pkg::hist_ctrl_t     ctrl,
    input  logic [SAMPLE_BITS-1:0]  sample,
    output logic [SAMPLE_BITS-1:0]  head
);

    logic [SAMPLE_BITS-1:0] hist_reg [WINDOW_MAX];

    genvar i;
    generate
        for (i = 0; i < WINDOW_MAX; i++)
        begin : g_entry
            localparam int UP   = (i + 1) % WINDOW_MAX;
            localparam int DOWN = (i == 0) ? 0 : i - 1;
            always_ff @(posedge clk)
            begin
                if (ctrl.push)
                begin
                    if (i == 0)
                    begin
                        hist_reg[i] <= sample;
                    end
                    else
                    begin
                        hist_reg[i] <= hist_reg[DOWN];
                    end
                end
                else if (ctrl.rotate)
                begin
                    hist_reg[i] <= hist_reg[UP];
                end
            end
        end
    endgenerate

    assign head = hist_reg[0];

endmodule

/* rtl/sliding_median_spike_detector.sv */
// ----------------------------------------------------------------------------
// sliding_median_spike_detector: alert when a sample reaches twice the median
// Compares each sample with twice the median of the preceding window and counts
// alerts with a saturating counter.
//
// Usage: samples arrive on the samples channel, one result request per sample
// leaves on the results channel (valid/ready). cfg_we/cfg_data write the window
// length; write it only while the block is idle. A length of zero acts as one,
// a length above WINDOW_MAX acts as WINDOW_MAX.
// One sample is processed at a time. Before the window is full the result goes
// straight to the output register. Otherwise the window (L samples) is streamed
// through a row of insertion-sort cells while the history line rotates once,
// then the middle elements are shifted out of the row and the output register
// is loaded; the next sample can be taken once the result is valid.
// The result sits in an output register: a new sample is taken while it
// waits; a stalled receiver holds the block before its next result.
// Reset empties the history, clears the alert count and sets the length to 1.
// ----------------------------------------------------------------------------
module sliding_median_spike_detector #(
    parameter int WINDOW_MAX  = smd_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = smd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [smd_pkg::CFG_BITS-1:0]  cfg_data,
    smd_in_if.sink                        samples,
    smd_out_if.source                     results
);

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SORT = 4'b0010,
        S_PICK = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [smd_pkg::CFG_BITS-1:0]    wlen_reg;
    logic [LEN_W-1:0]                fill_reg, fill_next;
    logic [LEN_W-1:0]                len_reg, len_next;
    logic [LEN_W-1:0]                cnt_reg, cnt_next;
    logic [smd_pkg::COUNT_BITS-1:0]  alerts_reg, alerts_next;
    logic                            win_ok_reg, win_ok_next;
    logic [SAMPLE_BITS-1:0]          sample_reg, sample_next;
    logic [SAMPLE_BITS-1:0]          lo_reg, lo_next;
    logic [SAMPLE_BITS:0]            twice_reg, twice_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            out_ready_bit_reg, out_ready_bit_next;
    logic                            out_alert_reg, out_alert_next;
    logic [SAMPLE_BITS:0]            out_twice_reg, out_twice_next;
    logic [smd_pkg::COUNT_BITS-1:0]  out_count_reg, out_count_next;

    logic [LEN_W-1:0]                len_eff;
    logic [LEN_W-1:0]                hi_idx;
    logic [LEN_W-1:0]                lo_idx;
    logic [SAMPLE_BITS-1:0]          lo_sel;
    logic                            in_take;
    logic                            inflight;
    logic                            alert_now;
    logic [SAMPLE_BITS-1:0]          head;
    smd_pkg::hist_ctrl_t             hctrl;
    smd_pkg::cell_ctrl_t             cctrl;
    logic                            feed_valid;

    logic [SAMPLE_BITS-1:0]          held   [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0]          pdata  [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]           pvalid;

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(wlen_reg) > 32'(WINDOW_MAX))
        begin
            len_eff = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            len_eff = LEN_W'(wlen_reg);
        end
    end

    assign in_take    = samples.valid && samples.ready;
    assign inflight   = |pvalid;
    assign hi_idx     = len_reg >> 1;
    assign lo_idx     = len_reg[0] ? hi_idx : hi_idx - LEN_W'(1);
    assign lo_sel     = (cnt_reg == lo_idx) ? held[0] : lo_reg;
    assign feed_valid = (state_reg == S_SORT) && (cnt_reg < len_reg);
    assign alert_now  = win_ok_reg && ({1'b0, sample_reg} >= twice_reg);

    always_comb
    begin
        state_next         = state_reg;
        fill_next          = fill_reg;
        len_next           = len_reg;
        cnt_next           = cnt_reg;
        alerts_next        = alerts_reg;
        win_ok_next        = win_ok_reg;
        sample_next        = sample_reg;
        lo_next            = lo_reg;
        twice_next         = twice_reg;
        out_valid_next     = out_valid_reg;
        out_ready_bit_next = out_ready_bit_reg;
        out_alert_next     = out_alert_reg;
        out_twice_next     = out_twice_reg;
        out_count_next     = out_count_reg;
        hctrl              = '0;
        cctrl              = '0;

        if (results.valid && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    sample_next = samples.sample;
                    len_next    = len_eff;
                    cnt_next    = '0;
                    twice_next  = '0;
                    cctrl.clear = 1'b1;
                    if (fill_reg >= len_eff)
                    begin
                        win_ok_next = 1'b1;
                        state_next  = S_SORT;
                    end
                    else
                    begin
                        win_ok_next = 1'b0;
                        state_next  = S_OUT;
                    end
                end
            end
            S_SORT:
            begin
                cctrl.sort = 1'b1;
                if (cnt_reg != LEN_W'(WINDOW_MAX))
                begin
                    hctrl.rotate = 1'b1;
                    cnt_next     = cnt_reg + LEN_W'(1);
                end
                else if (!inflight)
                begin
                    cnt_next   = '0;
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                cctrl.shift = 1'b1;
                cnt_next    = cnt_reg + LEN_W'(1);
                if (cnt_reg == lo_idx)
                begin
                    lo_next = held[0];
                end
                if (cnt_reg == hi_idx)
                begin
                    twice_next = {1'b0, lo_sel} + {1'b0, held[0]};
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    hctrl.push = 1'b1;
                    if (fill_reg != LEN_W'(WINDOW_MAX))
                    begin
                        fill_next = fill_reg + LEN_W'(1);
                    end
                    if (alert_now && (alerts_reg != '1))
                    begin
                        alerts_next    = alerts_reg + 1'b1;
                        out_count_next = alerts_reg + 1'b1;
                    end
                    else
                    begin
                        out_count_next = alerts_reg;
                    end
                    out_valid_next     = 1'b1;
                    out_ready_bit_next = win_ok_reg;
                    out_alert_next     = alert_now;
                    out_twice_next     = twice_reg;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wlen_reg      <= smd_pkg::CFG_BITS'(1);
            fill_reg      <= '0;
            alerts_reg    <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            alerts_reg    <= alerts_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                wlen_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg           <= len_next;
        win_ok_reg        <= win_ok_next;
        sample_reg        <= sample_next;
        lo_reg            <= lo_next;
        twice_reg         <= twice_next;
        out_ready_bit_reg <= out_ready_bit_next;
        out_alert_reg     <= out_alert_next;
        out_twice_reg     <= out_twice_next;
        out_count_reg     <= out_count_next;
    end

    smd_hist #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_hist (
        .clk    (clk),
        .ctrl   (hctrl),
        .sample (sample_reg),
        .head   (head)
    );

    genvar k;
    generate
        for (k = 0; k < WINDOW_MAX; k++)
        begin : g_cell
            logic                   c_in_valid;
            logic [SAMPLE_BITS-1:0] c_in_data;
            logic [SAMPLE_BITS-1:0] c_shift;
            if (k == 0)
            begin : g_first
                assign c_in_valid = feed_valid;
                assign c_in_data  = head;
            end
            else
            begin : g_rest
                assign c_in_valid = pvalid[k-1];
                assign c_in_data  = pdata[k-1];
            end
            if (k == WINDOW_MAX - 1)
            begin : g_last
                assign c_shift = '0;
            end
            else
            begin : g_mid
                assign c_shift = held[k+1];
            end
            smd_sort_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cctrl),
                .in_valid   (c_in_valid),
                .in_data    (c_in_data),
                .shift_data (c_shift),
                .held       (held[k]),
                .pass_valid (pvalid[k]),
                .pass_data  (pdata[k])
            );
        end
    endgenerate

    assign samples.ready        = (state_reg == S_IDLE);
    assign results.valid        = out_valid_reg;
    assign results.window_ready = out_ready_bit_reg;
    assign results.alert        = out_alert_reg;
    assign results.twice_median = out_twice_reg;
    assign results.alert_count  = out_count_reg;

    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.window_ready) |->
            (!results.alert && (results.twice_median == '0)))
        else $error("result without full window carries a median or alert");

    a_sort_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK) |-> !inflight)
        else $error("sorter still moving data while middle elements are read");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(WINDOW_MAX))
        else $error("fill level beyond window depth");

    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> (alerts_reg >= $past(alerts_reg)))
        else $error("alert counter went backwards");

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the sliding median spike detector
// Streams samples through the request channel under bursty input and a stalling
// receiver, predicts each result from a local copy of the history line and the
// window length, and compares every result field by field. Covers short and
// clamped window lengths, length changes on a filled history, the alert
// boundary and a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb;

    localparam int SAMPLE_BITS  = smd_pkg::SAMPLE_BITS_DEF;
    localparam int WINDOW_MAX   = smd_pkg::WINDOW_MAX_DEF;
    localparam int RANDOM_ITEMS = 1750;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 200;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct packed {
        logic                 window_ready;
        logic                 alert;
        logic [SAMPLE_BITS:0] twice_median;
        logic [31:0]          alert_count;
    } median_verdict_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [smd_pkg::CFG_BITS-1:0] cfg_data;

    smd_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) samp_ch ();
    smd_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) res_ch ();

    sliding_median_spike_detector #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .samples  (samp_ch),
        .results  (res_ch)
    );

    logic [SAMPLE_BITS-1:0]           hist_line [WINDOW_MAX];
    int                               fill_count;
    logic [31:0]                      alert_total;
    logic [smd_pkg::CFG_BITS-1:0]     window_len;

    median_verdict_t verdict_queue [$];
    int  error_count;
    int  samples_sent;
    int  random_items;
    int  length_writes;
    int  burst_left;
    bit  offering;
    bit  long_hold_request;
    int  cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, verdict_queue.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic int applied_length();
        if (window_len == 0)
            return 1;
        if (int'(window_len) > WINDOW_MAX)
            return WINDOW_MAX;
        return int'(window_len);
    endfunction

    function automatic logic [SAMPLE_BITS:0] twice_median_of(input int len);
        logic [SAMPLE_BITS-1:0] win [WINDOW_MAX];
        logic [SAMPLE_BITS-1:0] v;
        int i;
        int j;
        for (i = 0; i < len; i++)
        begin
            v = hist_line[i];
            j = i;
            while (j > 0 && win[j-1] > v)
            begin
                win[j] = win[j-1];
                j--;
            end
            win[j] = v;
        end
        if (len % 2 == 1)
            return {win[len/2], 1'b0};
        return {1'b0, win[len/2-1]} + {1'b0, win[len/2]};
    endfunction

    function automatic median_verdict_t predict_verdict(input logic [SAMPLE_BITS-1:0] s);
        median_verdict_t v;
        int len;
        int i;
        len = applied_length();
        v.window_ready = 1'b0;
        v.alert        = 1'b0;
        v.twice_median = '0;
        if (fill_count >= len)
        begin
            v.window_ready = 1'b1;
            v.twice_median = twice_median_of(len);
            if ({1'b0, s} >= v.twice_median)
            begin
                v.alert = 1'b1;
                if (alert_total != 32'hFFFF_FFFF)
                    alert_total++;
            end
        end
        v.alert_count = alert_total;
        for (i = WINDOW_MAX - 1; i > 0; i--)
            hist_line[i] = hist_line[i-1];
        hist_line[0] = s;
        if (fill_count < WINDOW_MAX)
            fill_count++;
        return v;
    endfunction

    function automatic void report_field(input string name, input logic [31:0] exp_val,
                                         input logic [31:0] got_val);
        error_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, got_val);
    endfunction

    // check each accepted result against the oldest prediction
    initial
    begin : verdict_check
        median_verdict_t exp_v;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                if (verdict_queue.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual twice_median %0d",
                             $time, res_ch.twice_median);
                end
                else
                begin
                    exp_v = verdict_queue.pop_front();
                    if (res_ch.window_ready !== exp_v.window_ready)
                        report_field("window_ready", 32'(exp_v.window_ready),
                                     32'(res_ch.window_ready));
                    if (res_ch.alert !== exp_v.alert)
                        report_field("alert", 32'(exp_v.alert), 32'(res_ch.alert));
                    if (res_ch.twice_median !== exp_v.twice_median)
                        report_field("twice_median", 32'(exp_v.twice_median),
                                     32'(res_ch.twice_median));
                    if (res_ch.alert_count !== exp_v.alert_count)
                        report_field("alert_count", exp_v.alert_count, res_ch.alert_count);
                end
            end
        end
    end

    // receiver: stall patterns that change over time, plus one long hold-off
    initial
    begin : result_sink
        int stall_mode;
        int mode_left;
        int hold_left;
        int tick;
        stall_mode = 0;
        mode_left  = 0;
        hold_left  = 0;
        tick       = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (long_hold_request)
            begin
                long_hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 300);
                end
                mode_left--;
                case (stall_mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       res_ch.ready <= ($urandom_range(0, 1) != 0);
                    default: res_ch.ready <= (tick % 7 < 4);
                endcase
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
        int gap;
        samp_ch.sample <= s;
        if (!offering)
        begin
            samp_ch.valid <= 1'b1;
            offering = 1'b1;
        end
        do
            @(posedge clk);
        while (samp_ch.ready !== 1'b1);
        verdict_queue.insert(verdict_queue.size(), predict_verdict(s));
        samples_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                samp_ch.valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        if (offering)
        begin
            samp_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        while (verdict_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_window_length(input logic [smd_pkg::CFG_BITS-1:0] len);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= len;
        @(posedge clk);
        cfg_we   <= 1'b0;
        window_len = len;
        length_writes++;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int mode, input int base);
        int roll;
        int val;
        logic [SAMPLE_BITS:0] tm;
        roll = $urandom_range(0, 99);
        if (mode == 0)
            return SAMPLE_BITS'($urandom_range(0, 65535));
        if (mode == 1)
            return SAMPLE_BITS'($urandom_range(0, 15));
        // hit the alert boundary exactly or one below it
        if (fill_count >= applied_length() && roll < 12)
        begin
            tm = twice_median_of(applied_length());
            if (tm <= 65535)
                return SAMPLE_BITS'(tm[SAMPLE_BITS-1:0] - $urandom_range(0, 1));
        end
        if (roll < 28)
            val = 2 * base + $urandom_range(0, base);
        else
            val = base + $urandom_range(0, base / 4) - base / 8;
        if (val > 65535)
            val = 65535;
        return SAMPLE_BITS'(val);
    endfunction

    task automatic test_window_of_one();
        send_sample(16'd100);
        send_sample(16'd200);
        send_sample(16'd399);
        send_sample(16'd0);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'h8000);
    endtask

    task automatic test_even_and_odd_windows();
        write_window_length(7'd2);
        send_sample(16'd10);
        send_sample(16'd30);
        send_sample(16'd40);
        send_sample(16'd39);
        send_sample(16'h5555);
        write_window_length(7'd3);
        send_sample(16'd5);
        send_sample(16'd5);
        send_sample(16'd10);
        send_sample(16'hAAAA);
    endtask

    task automatic test_length_clamping();
        write_window_length(7'd0);
        send_sample(16'd1);
        send_sample(16'd2);
        write_window_length(7'd127);
        send_sample(16'd7);
        send_sample(16'hFFFF);
    endtask

    task automatic test_receiver_hold_off();
        int k;
        drain_results();
        long_hold_request = 1'b1;
        for (k = 0; k < 8; k++)
            send_sample(SAMPLE_BITS'($urandom_range(0, 65535)));
        drain_results();
    endtask

    task automatic test_random_stream();
        int len;
        int count;
        int mode;
        int base;
        int roll;
        int k;
        while (random_items < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
                len = 0;
            else if (roll == 1)
                len = 127;
            else if (roll == 2)
                len = $urandom_range(64, 126);
            else if (roll <= 5)
                len = $urandom_range(10, 63);
            else
                len = $urandom_range(1, 9);
            write_window_length(smd_pkg::CFG_BITS'(len));
            mode  = $urandom_range(0, 5);
            base  = $urandom_range(50, 20000);
            count = (applied_length() >= 32) ? $urandom_range(15, 30) : $urandom_range(20, 60);
            for (k = 0; k < count; k++)
            begin
                send_sample(pick_sample(mode, base));
                random_items++;
            end
        end
        drain_results();
    endtask

    initial
    begin
        int i;
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        samp_ch.valid  <= 1'b0;
        samp_ch.sample <= '0;
        for (i = 0; i < WINDOW_MAX; i++)
            hist_line[i] = '0;
        fill_count        = 0;
        alert_total       = '0;
        window_len        = 1;
        error_count       = 0;
        samples_sent      = 0;
        random_items      = 0;
        length_writes     = 0;
        burst_left        = 0;
        offering          = 1'b0;
        long_hold_request = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_window_of_one();
        test_even_and_odd_windows();
        test_length_clamping();
        test_receiver_hold_off();
        test_random_stream();

        drain_results();
        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d samples with %0d alerts over %0d window length writes,",
                 samples_sent, alert_total, length_writes);
        $display("lengths 0 to 127 including clamped ones, and one %0d-cycle receiver hold-off.",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
